FILE: rtl/mwc_pkg.sv
package mwc_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int OUT_W      = 21;
  localparam int CEIL_W     = 20;
  localparam int SOFT_W     = 16;
  localparam int PEAK_IN_W  = 23;
  localparam int PEAK_OUT_W = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int TANH_DEPTH = 1024;
  localparam int TANH_IDX_W = $clog2(TANH_DEPTH);
  localparam int TANH_LAST  = TANH_DEPTH - 1;
  localparam int TANH_W     = 31;
  localparam int FRAC_W     = 16;
  localparam int QUOT_W     = TANH_IDX_W + FRAC_W;
  localparam int DIVR_W     = 42;
  localparam int REM_W      = DIVR_W + 1;
  localparam int NUM_W      = 47;
  localparam int PNUM_W     = NUM_W + TANH_IDX_W;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 24;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int CNT_W      = $clog2(QUOT_W + 1);

  localparam logic [TANH_W-1:0]     Q30_ONE  = TANH_W'(1) << 30;
  localparam logic [CEIL_W:0]       OUT_MAX  = (CEIL_W + 1)'(524288);
  localparam logic [CEIL_W-1:0]     EPS_CEIL = CEIL_W'(52);
  localparam logic [SOFT_W-1:0]     SOFT_MIN = SOFT_W'(4096);
  localparam logic [CEIL_W-1:0]     CEIL_RST = CEIL_W'(494984);
  localparam logic [SOFT_W-1:0]     SOFT_RST = SOFT_W'(22118);

  typedef enum logic [1:0] {
    MODE_SOFT = 2'd0,
    MODE_HARD = 2'd1,
    MODE_ASYM = 2'd2,
    MODE_PASS = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 2'd0,
    REG_CEIL = 2'd1,
    REG_SOFT = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISP,
    ST_NC_MUL,
    ST_NC_DIV,
    ST_NC_WAIT,
    ST_SSN,
    ST_DEN,
    ST_NUM,
    ST_T_CHK,
    ST_T_WAIT,
    ST_T_RD0,
    ST_T_RD1,
    ST_T_MUL,
    ST_T_INT,
    ST_Y_MUL,
    ST_Y_DIV,
    ST_Y_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              start;
    logic [REM_W-1:0]  rem_init;
    logic [QUOT_W-1:0] shift_in;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef logic [TANH_W-1:0] tanh_rom_t [TANH_DEPTH];

  // shift-and-subtract quotient, used only while building the table
  function automatic longint unsigned udiv_u64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int k = 63; k >= 0; k--) begin
      r = (r << 1) | ((a >> k) & 64'd1);
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // tanh(8*i/(DEPTH-1)) in Q30, from a series for exp(-2a/32) squared five times
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t       rom;
    longint unsigned one;
    longint unsigned t;
    longint unsigned term;
    longint unsigned e;
    longint          sum;
    one = 64'd1 << 30;
    for (int i = 0; i < TANH_DEPTH; i++) begin
      t    = udiv_u64(longint'(i) << 30, 64'(2 * TANH_LAST));
      term = one;
      sum  = longint'(one);
      for (int n = 1; n <= 14; n++) begin
        term = udiv_u64((term * t) >> 30, 64'(n));
        if ((n % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      e = (sum < 0) ? 64'd0 : longint'(sum);
      for (int n = 0; n < 5; n++) begin
        e = (e * e + (one >> 1)) >> 30;
      end
      if (e > one) e = one;
      rom[i] = TANH_W'(udiv_u64(((one - e) << 30) + ((one + e) >> 1), one + e));
    end
    return rom;
  endfunction

endpackage

FILE: rtl/mwc_div.sv
module mwc_div import mwc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [QUOT_W-1:0] sh_q, sh_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [DIVR_W-1:0] dvr_q, dvr_d;
  logic [REM_W-1:0]  trial;
  logic              ge;

  always_comb begin
    trial  = {rem_q[REM_W-2:0], sh_q[QUOT_W-1]};
    ge     = trial >= {1'b0, dvr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quot_d = quot_q;
    dvr_d  = dvr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUOT_W);
      rem_d  = req_i.rem_init;
      sh_d   = req_i.shift_in;
      dvr_d  = req_i.divisor;
    end else if (busy_q) begin
      // one quotient bit per cycle, restoring
      rem_d  = ge ? (trial - {1'b0, dvr_q}) : trial;
      sh_d   = {sh_q[QUOT_W-2:0], 1'b0};
      quot_d = {quot_q[QUOT_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    quot_q <= quot_d;
    dvr_q  <= dvr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/multimode_waveshape_clipper.sv
// Waveshaping clipper: soft tanh, hard limit, asymmetric tanh or pass-through.
// Input stream: tdata holds the signed Q19 sample (24 bits), tlast marks the
// final sample of a metering block. Output stream: tdata holds the clipped
// sample, the running input peak and the running output peak; tlast copies
// the input tlast. Peaks include the current sample and clear after a tlast.
// Configuration channel: index 0 curve mode, 1 ceiling, 2 softness; write
// only while no sample is in flight.
// One sample is handled at a time by a shared multiplier and a shared
// restoring divider that yields one quotient bit per cycle, for a 26-bit quotient.
// Hard and pass-through modes go from dispatch straight to the result; a soft
// curve needs up to three divides and two table lookups, and the negative
// branch of the asymmetric curve needs up to four divides.
// A new sample can be taken in the cycle after the previous result is issued.
// The next sample is accepted while a finished result waits in the output
// register; a stalled receiver holds that result and, once the next result
// is ready, the sequencer waits.
// Reset restores the default configuration and clears both peaks.
module multimode_waveshape_clipper import mwc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata_i,  // [23:0] sample_in
  input  logic                  s_axis_tlast_i,  // block_last
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [63:0]           m_axis_tdata_o,  // [20:0] sample_out, [43:21] peak_before,
                                                 // [63:44] peak_after
  output logic                  m_axis_tlast_o,  // last_out
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

  state_e                 state_q, state_d;
  mode_e                  mode_q, mode_d;
  logic [CEIL_W-1:0]      ceil_q, ceil_d;
  logic [SOFT_W-1:0]      soft_q, soft_d;
  logic [PEAK_IN_W-1:0]   pin_q, pin_d;
  logic [PEAK_OUT_W-1:0]  pout_q, pout_d;
  logic                   mval_q, mval_d;
  logic [63:0]            mdata_q, mdata_d;
  logic                   mlast_q, mlast_d;

  logic [SAMPLE_W-1:0]    ax_q, ax_d;
  logic                   neg_q, neg_d;
  logic                   last_q, last_d;
  logic                   alt_q, alt_d;
  logic                   ph_q, ph_d;
  logic                   up_q, up_d;
  logic [CEIL_W-1:0]      ceff_q, ceff_d;
  logic [22:0]            ssn_q, ssn_d;
  logic [26:0]            cmsd_q, cmsd_d;
  logic [NUM_W-1:0]       num_q, num_d;
  logic [TANH_W-1:0]      td_q, td_d;
  logic [TANH_W-1:0]      tn_q, tn_d;
  logic [TANH_W-1:0]      lo_q, lo_d;
  logic [TANH_IDX_W-1:0]  idx_q, idx_d;
  logic [FRAC_W-1:0]      frac_q, frac_d;
  logic [CEIL_W:0]        y_q, y_d;
  logic [PROD_W-1:0]      prod_q;

  logic [TANH_IDX_W-1:0]  rom_addr;
  logic [TANH_W-1:0]      rom_q;

  logic [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]     mul_b;
  logic                   mul_en;

  div_req_t               div_req;
  logic                   div_done;
  logic [QUOT_W-1:0]      div_quot;

  logic [SAMPLE_W-1:0]    in_mag;
  logic [SOFT_W-1:0]      s_eff;
  logic [CEIL_W-1:0]      cm;
  logic [6:0]             sn;
  logic [6:0]             sd;
  logic [NUM_W-1:0]       tnum;
  logic [DIVR_W-1:0]      tden8;
  logic [PNUM_W-1:0]      pnum;
  logic [26:0]            nc_v;
  logic [51:0]            y_v;
  logic [TANH_W-1:0]      interp;
  logic [SAMPLE_W-1:0]    hard_y;
  logic [PEAK_IN_W-1:0]   pk;
  logic [PEAK_IN_W-1:0]   pin_new;
  logic [PEAK_OUT_W-1:0]  pout_new;
  logic [OUT_W-1:0]       y_signed;

  mwc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i) begin
    rom_q <= TANH_ROM[rom_addr];
    if (mul_en) prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = mval_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tlast_o  = mlast_q;

  always_comb begin
    in_mag = s_axis_tdata_i[SAMPLE_W-1] ? (~s_axis_tdata_i + SAMPLE_W'(1)) : s_axis_tdata_i;
    s_eff  = (soft_q < SOFT_MIN) ? SOFT_MIN : soft_q;
    cm     = (ceff_q < EPS_CEIL) ? EPS_CEIL : ceff_q;
    sn     = alt_q ? 7'd115 : 7'd1;
    sd     = alt_q ? 7'd100 : 7'd1;
    if (!ph_q) begin
      tnum  = NUM_W'(ssn_q);
      tden8 = DIVR_W'(sd) << 15;
    end else begin
      tnum  = num_q;
      tden8 = DIVR_W'(cmsd_q) << 15;
    end
    pnum   = (PNUM_W'(tnum) << TANH_IDX_W) - PNUM_W'(tnum);
    nc_v   = prod_q[26:0] + 27'd50;
    y_v    = prod_q[51:0] + 52'(td_q >> 1);
    interp = up_q ? (lo_q + prod_q[FRAC_W +: TANH_W]) : (lo_q - prod_q[FRAC_W +: TANH_W]);
    hard_y = (ax_q > SAMPLE_W'(ceil_q)) ? SAMPLE_W'(ceil_q) : ax_q;
    pk     = ax_q[SAMPLE_W-1] ? {PEAK_IN_W{1'b1}} : ax_q[PEAK_IN_W-1:0];
    pin_new  = (pk > pin_q) ? pk : pin_q;
    pout_new = (y_q[PEAK_OUT_W-1:0] > pout_q) ? y_q[PEAK_OUT_W-1:0] : pout_q;
    y_signed = neg_q ? (OUT_W'(0) - OUT_W'(y_q)) : OUT_W'(y_q);
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    ceil_d  = ceil_q;
    soft_d  = soft_q;
    pin_d   = pin_q;
    pout_d  = pout_q;
    mval_d  = mval_q;
    mdata_d = mdata_q;
    mlast_d = mlast_q;
    ax_d    = ax_q;
    neg_d   = neg_q;
    last_d  = last_q;
    alt_d   = alt_q;
    ph_d    = ph_q;
    up_d    = up_q;
    ceff_d  = ceff_q;
    ssn_d   = ssn_q;
    cmsd_d  = cmsd_q;
    num_d   = num_q;
    td_d    = td_q;
    tn_d    = tn_q;
    lo_d    = lo_q;
    idx_d   = idx_q;
    frac_d  = frac_q;
    y_d     = y_q;
    rom_addr = idx_q;
    mul_a   = '0;
    mul_b   = '0;
    mul_en  = 1'b0;
    div_req = '0;

    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_MODE: mode_d = mode_e'(cfg_data_i[1:0]);
        REG_CEIL: ceil_d = cfg_data_i[CEIL_W-1:0];
        REG_SOFT: soft_d = cfg_data_i[SOFT_W-1:0];
        default:  ;
      endcase
    end

    if (mval_q && m_axis_tready_i) mval_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          ax_d    = in_mag;
          neg_d   = s_axis_tdata_i[SAMPLE_W-1];
          last_d  = s_axis_tlast_i;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        ph_d   = 1'b0;
        alt_d  = 1'b0;
        ceff_d = ceil_q;
        case (mode_q)
          MODE_SOFT: state_d = ST_SSN;
          MODE_HARD: begin
            y_d     = (hard_y > SAMPLE_W'(OUT_MAX)) ? OUT_MAX : hard_y[CEIL_W:0];
            state_d = ST_DONE;
          end
          MODE_ASYM: state_d = neg_q ? ST_NC_MUL : ST_SSN;
          default: begin
            y_d     = (ax_q > SAMPLE_W'(OUT_MAX)) ? OUT_MAX : ax_q[CEIL_W:0];
            state_d = ST_DONE;
          end
        endcase
      end
      ST_NC_MUL: begin
        mul_a   = MUL_A_W'(ceil_q);
        mul_b   = MUL_B_W'(78);
        mul_en  = 1'b1;
        state_d = ST_NC_DIV;
      end
      ST_NC_DIV: begin
        div_req.start    = 1'b1;
        div_req.rem_init = REM_W'(nc_v[26:QUOT_W]);
        div_req.shift_in = nc_v[QUOT_W-1:0];
        div_req.divisor  = DIVR_W'(100);
        state_d          = ST_NC_WAIT;
      end
      ST_NC_WAIT: begin
        if (div_done) begin
          ceff_d  = div_quot[CEIL_W-1:0];
          alt_d   = 1'b1;
          state_d = ST_SSN;
        end
      end
      ST_SSN: begin
        mul_a   = MUL_A_W'(s_eff);
        mul_b   = MUL_B_W'(sn);
        mul_en  = 1'b1;
        state_d = ST_DEN;
      end
      ST_DEN: begin
        ssn_d   = prod_q[22:0];
        mul_a   = MUL_A_W'(cm);
        mul_b   = MUL_B_W'(sd);
        mul_en  = 1'b1;
        state_d = ST_NUM;
      end
      ST_NUM: begin
        cmsd_d  = prod_q[26:0];
        mul_a   = MUL_A_W'(ax_q);
        mul_b   = MUL_B_W'(ssn_q);
        mul_en  = 1'b1;
        state_d = ST_T_CHK;
      end
      ST_T_CHK: begin
        if (ph_q == 1'b0) num_d = prod_q[NUM_W-1:0];
        if (NUM_W'(tden8) <= tnum) begin
          // argument at or beyond the table end: tanh is exactly one
          if (!ph_q) begin
            td_d = Q30_ONE;
            ph_d = 1'b1;
          end else begin
            tn_d    = Q30_ONE;
            state_d = ST_Y_MUL;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = REM_W'(pnum[PNUM_W-1:TANH_IDX_W]);
          div_req.shift_in = {pnum[TANH_IDX_W-1:0], {FRAC_W{1'b0}}};
          div_req.divisor  = tden8;
          state_d          = ST_T_WAIT;
        end
      end
      ST_T_WAIT: begin
        if (div_done) begin
          idx_d   = div_quot[QUOT_W-1:FRAC_W];
          frac_d  = div_quot[FRAC_W-1:0];
          state_d = ST_T_RD0;
        end
      end
      ST_T_RD0: begin
        rom_addr = idx_q;
        state_d  = ST_T_RD1;
      end
      ST_T_RD1: begin
        rom_addr = idx_q + TANH_IDX_W'(1);
        lo_d     = rom_q;
        state_d  = ST_T_MUL;
      end
      ST_T_MUL: begin
        up_d    = rom_q >= lo_q;
        mul_a   = MUL_A_W'((rom_q >= lo_q) ? (rom_q - lo_q) : (lo_q - rom_q));
        mul_b   = MUL_B_W'(frac_q);
        mul_en  = 1'b1;
        state_d = ST_T_INT;
      end
      ST_T_INT: begin
        if (!ph_q) begin
          td_d    = interp;
          ph_d    = 1'b1;
          state_d = ST_T_CHK;
        end else begin
          tn_d    = interp;
          state_d = ST_Y_MUL;
        end
      end
      ST_Y_MUL: begin
        mul_a   = MUL_A_W'(tn_q);
        mul_b   = MUL_B_W'(ceff_q);
        mul_en  = 1'b1;
        state_d = ST_Y_DIV;
      end
      ST_Y_DIV: begin
        div_req.start    = 1'b1;
        div_req.rem_init = REM_W'(y_v[51:QUOT_W]);
        div_req.shift_in = y_v[QUOT_W-1:0];
        div_req.divisor  = DIVR_W'(td_q);
        state_d          = ST_Y_WAIT;
      end
      ST_Y_WAIT: begin
        if (div_done) begin
          y_d     = (div_quot > QUOT_W'(OUT_MAX)) ? OUT_MAX : div_quot[CEIL_W:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!mval_q || m_axis_tready_i) begin
          mval_d  = 1'b1;
          mdata_d = {pout_new, pin_new, y_signed};
          mlast_d = last_q;
          if (y_q == '0) mdata_d[OUT_W-1:0] = '0;
          pin_d   = last_q ? '0 : pin_new;
          pout_d  = last_q ? '0 : pout_new;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_SOFT;
      ceil_q  <= CEIL_RST;
      soft_q  <= SOFT_RST;
      pin_q   <= '0;
      pout_q  <= '0;
      mval_q  <= 1'b0;
      ph_q    <= 1'b0;
      alt_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      ceil_q  <= ceil_d;
      soft_q  <= soft_d;
      pin_q   <= pin_d;
      pout_q  <= pout_d;
      mval_q  <= mval_d;
      ph_q    <= ph_d;
      alt_q   <= alt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mdata_q <= mdata_d;
    mlast_q <= mlast_d;
    ax_q    <= ax_d;
    neg_q   <= neg_d;
    last_q  <= last_d;
    up_q    <= up_d;
    ceff_q  <= ceff_d;
    ssn_q   <= ssn_d;
    cmsd_q  <= cmsd_d;
    num_q   <= num_d;
    td_q    <= td_d;
    tn_q    <= tn_d;
    lo_q    <= lo_d;
    idx_q   <= idx_d;
    frac_q  <= frac_d;
    y_q     <= y_d;
  end

`ifndef ASSERT_OFF
  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mval_q) |-> $past(state_q) == ST_DONE)
    else $error("result appeared without a finished sample");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_T_WAIT || state_q == ST_NC_WAIT || state_q == ST_Y_WAIT))
    else $error("divider finished while no one waits");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mval_q |-> ($signed(mdata_q[OUT_W-1:0]) <= $signed(OUT_W'(OUT_MAX))
             && $signed(mdata_q[OUT_W-1:0]) >= -$signed(OUT_W'(OUT_MAX))))
    else $error("clipped sample out of range");

  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mval_q && !mdata_q[OUT_W-1]) |-> mdata_q[63:44] >= mdata_q[PEAK_OUT_W-1:0])
    else $error("output peak below current sample");

  a_y_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> y_q <= OUT_MAX)
    else $error("magnitude exceeds full scale");
`endif

endmodule

FILE: sim/testbench.sv
module testbench;
  import mwc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [OUT_W-1:0]      shaped;
    logic [PEAK_IN_W-1:0]  in_peak;
    logic [PEAK_OUT_W-1:0] out_peak;
    logic                  last;
  } clip_result_t;

  class clip_scoreboard;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned SAT_OUT = 64'd524288;
    localparam longint unsigned MIN_DIV = 64'd52;

    longint unsigned  tanh_tab[TANH_DEPTH];
    mode_e            mode;
    longint unsigned  ceiling;
    longint unsigned  softness;
    longint unsigned  in_peak;
    longint unsigned  out_peak;
    clip_result_t     pending_q[$];
    int               errors;
    int               checked;
    int               mode_hits[4];

    function new();
      longint unsigned t, term, e;
      longint          sum;
      for (int i = 0; i < TANH_DEPTH; i++) begin
        t    = (longint'(i) << 30) / (2 * (TANH_DEPTH - 1));
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        for (int n = 1; n <= 14; n++) begin
          term = ((term * t) >> 30) / longint'(n);
          if (n % 2) sum -= longint'(term);
          else sum += longint'(term);
        end
        e = (sum < 0) ? 0 : longint'(sum);
        for (int n = 0; n < 5; n++) e = (e * e + (ONE_Q30 >> 1)) >> 30;
        if (e > ONE_Q30) e = ONE_Q30;
        tanh_tab[i] = (((ONE_Q30 - e) << 30) + ((ONE_Q30 + e) >> 1)) / (ONE_Q30 + e);
      end
      mode     = MODE_SOFT;
      ceiling  = 494984;
      softness = 22118;
      in_peak  = 0;
      out_peak = 0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE: mode = mode_e'(data[1:0]);
        REG_CEIL: ceiling = data;
        REG_SOFT: softness = data[SOFT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned tanh_interp(longint unsigned num, longint unsigned den);
      longint unsigned pnum, pden, idx, rem, frac, lo, hi;
      if (num >= den * 8) return ONE_Q30;
      pnum = num * (TANH_DEPTH - 1);
      pden = den * 8;
      idx  = pnum / pden;
      rem  = pnum - idx * pden;
      frac = (rem << 16) / pden;
      if (idx >= TANH_DEPTH - 1) return tanh_tab[TANH_DEPTH-1];
      lo = tanh_tab[idx];
      hi = tanh_tab[idx+1];
      if (hi >= lo) return lo + (((hi - lo) * frac) >> 16);
      return lo - (((lo - hi) * frac) >> 16);
    endfunction

    function longint unsigned soft_curve(longint unsigned mag, longint unsigned ceff,
                                         longint unsigned drive, longint unsigned dn,
                                         longint unsigned dd);
      longint unsigned cdiv, tn, td, y;
      cdiv = (ceff < MIN_DIV) ? MIN_DIV : ceff;
      tn   = tanh_interp(mag * drive * dn, cdiv * 4096 * dd);
      td   = tanh_interp(drive * dn, 4096 * dd);
      if (td == 0) return 0;
      y = (ceff * tn + td / 2) / td;
      return (y > SAT_OUT) ? SAT_OUT : y;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] raw, logic last);
      clip_result_t    r;
      longint unsigned mag, drive, y, pk;
      logic            neg;
      neg   = raw[SAMPLE_W-1];
      mag   = neg ? longint'((~raw + 1'b1) & 24'hFFFFFF) : longint'(raw);
      if (neg && mag == 0) mag = 64'd1 << 23;
      drive = (softness < 4096) ? 4096 : softness;
      mode_hits[mode]++;
      case (mode)
        MODE_SOFT: y = soft_curve(mag, ceiling, drive, 1, 1);
        MODE_HARD: begin
          y = (mag > ceiling) ? ceiling : mag;
          if (y > SAT_OUT) y = SAT_OUT;
        end
        MODE_ASYM: begin
          if (!neg) y = soft_curve(mag, ceiling, drive, 1, 1);
          else y = soft_curve(mag, (ceiling * 78 + 50) / 100, drive, 115, 100);
        end
        default: y = (mag > SAT_OUT) ? SAT_OUT : mag;
      endcase
      pk = (mag > 8388607) ? 8388607 : mag;
      if (pk > in_peak) in_peak = pk;
      if (y > out_peak) out_peak = y;
      r.shaped   = (neg && y != 0) ? OUT_W'(64'h200000 - y) : OUT_W'(y);
      r.in_peak  = PEAK_IN_W'(in_peak);
      r.out_peak = PEAK_OUT_W'(out_peak);
      r.last     = last;
      pending_q.insert(pending_q.size(), r);
      if (last) begin
        in_peak  = 0;
        out_peak = 0;
      end
    endfunction

    function void check_result(logic [63:0] data, logic last);
      clip_result_t r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tlast=%b", $time, data, last);
        errors++;
        return;
      end
      r = pending_q.pop_front();
      checked++;
      if (data[20:0] !== r.shaped) begin
        $display("%0t: sample_out expected %h actual %h", $time, r.shaped, data[20:0]);
        errors++;
      end
      if (data[43:21] !== r.in_peak) begin
        $display("%0t: peak_before expected %h actual %h", $time, r.in_peak, data[43:21]);
        errors++;
      end
      if (data[63:44] !== r.out_peak) begin
        $display("%0t: peak_after expected %h actual %h", $time, r.out_peak, data[63:44]);
        errors++;
      end
      if (last !== r.last) begin
        $display("%0t: last_out expected %b actual %b", $time, r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [SAMPLE_W-1:0]   s_axis_tdata_i = '0;
  logic                  s_axis_tlast_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [63:0]           m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  clip_scoreboard sb = new();
  int  hold_req  = 0;
  int  hold_seen = 0;
  int  hold_cnt  = 0;
  int  rx_gap    = 0;
  bit  rx_steady = 1'b0;
  int  sent      = 0;

  multimode_waveshape_clipper u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) sb.note_sample(s_axis_tdata_i, s_axis_tlast_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
  end

  // receiver: random stalls, a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt  = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready_i = 1'b0;
    end else if (rx_steady) begin
      m_axis_tready_i = 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready_i = 1'b0;
    end else begin
      m_axis_tready_i = 1'b1;
      if ($urandom_range(3) == 0)
        rx_gap = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    end
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic last, bit gaps);
    int idle;
    idle = 0;
    if (gaps && $urandom_range(2) == 0)
      idle = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    repeat (idle) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = smp;
    s_axis_tlast_i  = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent++;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    wait (sb.pending_q.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic configure(mode_e m, logic [CFG_DATA_W-1:0] ceil_v, logic [SOFT_W-1:0] soft_v);
    drain();
    write_reg(REG_MODE, CFG_DATA_W'(m));
    write_reg(REG_CEIL, ceil_v);
    write_reg(REG_SOFT, CFG_DATA_W'(soft_v));
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) return SAMPLE_W'($urandom_range(0, 1048576) - 524288);
    if (pick < 7) return SAMPLE_W'($urandom_range(0, 2097152) - 1048576);
    if (pick < 9) return SAMPLE_W'($urandom);
    return ($urandom_range(1)) ? 24'h800000 : 24'h7FFFFF;
  endfunction

  initial begin
    logic [SAMPLE_W-1:0] edge_vals[12];
    mode_e               m;
    edge_vals = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'h080000,
                  24'hF80000, 24'h078D88, 24'h040000, 24'hFC0000, 24'h555555, 24'hAAAAAA};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // defaults from reset, then directed corners in every mode
    rx_steady = 1'b1;
    for (int i = 0; i < 6; i++) send_sample(edge_vals[i], i == 5, 1'b0);
    for (int k = 0; k < 4; k++) begin
      configure(mode_e'(k), (k == 3) ? 20'hFFFFF : 20'd524288, (k == 2) ? 16'd49152 : 16'd4096);
      for (int i = 0; i < 5; i++) send_sample(edge_vals[(i * 3 + k) % 12], i == 4, 1'b0);
    end
    configure(MODE_SOFT, 20'd0, 16'd0);
    send_sample(24'h7FFFFF, 1'b0, 1'b0);
    send_sample(24'h800000, 1'b1, 1'b0);
    configure(MODE_ASYM, 20'd52, 16'hFFFF);
    send_sample(24'h000100, 1'b0, 1'b0);
    send_sample(24'hFFFF00, 1'b1, 1'b0);
    drain();
    write_reg(REG_NONE, 20'hFFFFF);
    rx_steady = 1'b0;

    for (int ph = 0; ph < 20; ph++) begin
      m = mode_e'((ph < 16) ? ph % 3 : $urandom_range(3));
      case (ph % 5)
        0: configure(m, 20'd131072, 16'd4096);
        1: configure(m, 20'd524288, 16'd49152);
        2: configure(m, CFG_DATA_W'($urandom_range(131072, 524288)),
                     SOFT_W'($urandom_range(4096, 49152)));
        3: configure(m, CFG_DATA_W'($urandom), SOFT_W'($urandom));
        default: configure(m, CFG_DATA_W'($urandom_range(0, 200)),
                           SOFT_W'($urandom_range(0, 4096)));
      endcase
      rx_steady = (ph % 7 == 6);
      if (ph == 3) hold_req++;
      for (int i = 0; i < 50; i++) send_sample(random_sample(), $urandom_range(7) == 0, !rx_steady);
      rx_steady = 1'b0;
    end

    wait (sb.pending_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d samples (soft %0d, hard %0d, asym %0d, pass %0d), %0d results checked",
             sent, sb.mode_hits[0], sb.mode_hits[1], sb.mode_hits[2], sb.mode_hits[3], sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS multimode_waveshape_clipper");
    end else begin
      $display("FAIL multimode_waveshape_clipper");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", sb.pending_q.size());
    $display("FAIL multimode_waveshape_clipper");
    $finish;
  end
endmodule
